### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the quaternion rotator.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define QVR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/qvr_pkg.sv
// Package for the quaternion vector rotator: field widths, register codes,
// output limits and the conjugate helper. No dependencies.
package qvr_pkg;

  localparam int QUAT_WIDTH         = 16;
  localparam int QUAT_EFF_WIDTH     = QUAT_WIDTH + 1;
  localparam int OUT_WIDTH          = 20;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int VEC_WIDTH_DEF      = 18;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam logic [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'h4000;

  localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 20'sh80000;

  localparam logic FUNC_ROTATE   = 1'b0;
  localparam logic FUNC_UNROTATE = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } cfg_reg_t;

  // Vector part of the quaternion, negated for unrotate. One extra bit
  // keeps the negation of the most negative code exact.
  function automatic logic signed [QUAT_EFF_WIDTH-1:0] quat_eff(
    input logic [QUAT_WIDTH-1:0] q,
    input logic                  fn
  );
    logic signed [QUAT_EFF_WIDTH-1:0] qs;
    qs = QUAT_EFF_WIDTH'(signed'(q));
    return (fn == FUNC_UNROTATE) ? -qs : qs;
  endfunction

endpackage

### rtl/quaternion_vector_rotate_top.sv
// Quaternion vector rotator, six-stage pipeline, one vector per cycle unless the output stalls.
// Depends on qvr_pkg and assert_macros.svh.
//
// Usage:
//   Write the quaternion (x, y, z, w; signed Q2.14) through the cfg channel,
//   index 0..3, while no item is in flight. cfg_ready is always high.
//   Each item on the in channel (func, vec_x/y/z) gives one item on the out
//   channel: rot_x/y/z = q v q* (func 0) or q* v q (func 1), rounded half
//   up, clipped to 20 bits, with saturated set when any component clipped.
// Throughput: one item per cycle while out_ready is high.
// Stages: 1 q x v products, 2 t = 2(q x v), 3 split partial products of
//   w*t and q x t, 4 recombine products, 5 sum and rounding offset,
//   6 shift, add v, saturate into the output register.
// Stall: with out_valid high and out_ready low the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// Reset: clears all valid bits and sets the quaternion to identity
//   (0, 0, 0, 1.0).
`include "assert_macros.svh"

module quaternion_vector_rotate_top #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]           cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     func,
  input  logic signed [VEC_WIDTH-1:0]              vec_x,
  input  logic signed [VEC_WIDTH-1:0]              vec_y,
  input  logic signed [VEC_WIDTH-1:0]              vec_z,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [qvr_pkg::OUT_WIDTH-1:0]     rot_x,
  output logic signed [qvr_pkg::OUT_WIDTH-1:0]     rot_y,
  output logic signed [qvr_pkg::OUT_WIDTH-1:0]     rot_z,
  output logic                                     saturated
);
  import qvr_pkg::*;

  localparam int QEW  = QUAT_EFF_WIDTH;
  localparam int PW1  = QEW + VEC_WIDTH;              // q * v
  localparam int CW   = PW1 + 1;                      // q x v
  localparam int TW0  = CW + 1;                       // 2 * (q x v)
  localparam int TRIM = (VEC_WIDTH > 29) ? (VEC_WIDTH - 29) : 0;
  localparam int TW   = TW0 - TRIM;
  localparam int LW   = (TW + 1) / 2;                 // low part of t
  localparam int HW   = TW - LW;                      // high part of t
  localparam int PLW  = QEW + LW + 1;
  localparam int PHW  = QEW + HW;
  localparam int PW2  = QEW + TW;                     // q * t, w * t
  localparam int KSH  = 2 * QUAT_FRAC_BITS - TRIM;
  localparam int SW   = ((PW2 + 2) > (KSH + 2)) ? (PW2 + 2) : (KSH + 2);
  localparam int RW   = SW + 1;
  localparam int NSTG = 6;

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (KSH - 1);

  // Configuration registers
  logic [QUAT_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_W_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        REG_QUAT_W: quat_w <= cfg_data;
        default:    quat_w <= quat_w;
      endcase
    end
  end

  // Pipeline control: all stages advance together
  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv       = !vld[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // Operands
  logic signed [VEC_WIDTH-1:0] vin [3];
  logic signed [QEW-1:0]       qe1 [3];
  logic signed [QEW-1:0]       qe3 [3];
  logic signed [QEW-1:0]       wext;
  logic                        s1_func, s2_func;

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;
  assign qe1[0] = quat_eff(quat_x, func);
  assign qe1[1] = quat_eff(quat_y, func);
  assign qe1[2] = quat_eff(quat_z, func);
  assign qe3[0] = quat_eff(quat_x, s2_func);
  assign qe3[1] = quat_eff(quat_y, s2_func);
  assign qe3[2] = quat_eff(quat_z, s2_func);
  assign wext   = QEW'(signed'(quat_w));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func <= func;
      s2_func <= s1_func;
    end
  end

  // Per-component datapath
  logic signed [VEC_WIDTH-1:0] s1_v [3], s2_v [3], s3_v [3], s4_v [3], s5_v [3];
  logic signed [PW1-1:0]       s1_ppos [3], s1_pneg [3];
  logic signed [TW-1:0]        s2_t [3];
  logic signed [LW:0]          t_lo [3];
  logic signed [HW-1:0]        t_hi [3];
  logic signed [PLW-1:0]       s3_wlo [3], s3_plo [3], s3_nlo [3];
  logic signed [PHW-1:0]       s3_whi [3], s3_phi [3], s3_nhi [3];
  logic signed [PW2-1:0]       s4_wt [3], s4_p [3], s4_n [3];
  logic signed [SW-1:0]        s5_s [3];
  logic signed [OUT_WIDTH-1:0] s6_rot [3];
  logic [2:0]                  clip;
  logic                        s6_sat;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;

    logic signed [CW-1:0]  c;
    logic signed [TW0-1:0] t_full;
    logic signed [SW-1:0]  sh;
    logic signed [RW-1:0]  r;

    assign c      = CW'(s1_ppos[i]) - CW'(s1_pneg[i]);
    assign t_full = TW0'(c) <<< 1;
    assign t_lo[i] = signed'({1'b0, s2_t[i][LW-1:0]});
    assign t_hi[i] = signed'(s2_t[i][TW-1:LW]);
    assign sh     = s5_s[i] >>> KSH;
    assign r      = RW'(sh) + RW'(s5_v[i]);
    assign clip[i] = (r > RW'(OUT_MAX)) || (r < RW'(OUT_MIN));

    always_ff @(posedge clk) begin
      if (adv) begin
        // stage 1: q x v partial products
        s1_v[i]    <= vin[i];
        s1_ppos[i] <= PW1'(qe1[A]) * PW1'(vin[B]);
        s1_pneg[i] <= PW1'(qe1[B]) * PW1'(vin[A]);
        // stage 2: t = 2 (q x v), floored by the trim
        s2_v[i]    <= s1_v[i];
        s2_t[i]    <= signed'(t_full[TW0-1:TRIM]);
        // stage 3: split products of w * t and q x t
        s3_v[i]    <= s2_v[i];
        s3_wlo[i]  <= PLW'(wext) * PLW'(t_lo[i]);
        s3_whi[i]  <= PHW'(wext) * PHW'(t_hi[i]);
        s3_plo[i]  <= PLW'(qe3[A]) * PLW'(t_lo[B]);
        s3_phi[i]  <= PHW'(qe3[A]) * PHW'(t_hi[B]);
        s3_nlo[i]  <= PLW'(qe3[B]) * PLW'(t_lo[A]);
        s3_nhi[i]  <= PHW'(qe3[B]) * PHW'(t_hi[A]);
        // stage 4: recombine high and low halves
        s4_v[i]    <= s3_v[i];
        s4_wt[i]   <= (PW2'(s3_whi[i]) <<< LW) + PW2'(s3_wlo[i]);
        s4_p[i]    <= (PW2'(s3_phi[i]) <<< LW) + PW2'(s3_plo[i]);
        s4_n[i]    <= (PW2'(s3_nhi[i]) <<< LW) + PW2'(s3_nlo[i]);
        // stage 5: s = w t + q x t, plus the rounding offset
        s5_v[i]    <= s4_v[i];
        s5_s[i]    <= SW'(s4_wt[i]) + SW'(s4_p[i]) - SW'(s4_n[i]) + HALF;
        // stage 6: scale back, add v, clip
        if (r > RW'(OUT_MAX)) begin
          s6_rot[i] <= OUT_MAX;
        end else if (r < RW'(OUT_MIN)) begin
          s6_rot[i] <= OUT_MIN;
        end else begin
          s6_rot[i] <= r[OUT_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sat <= |clip;
    end
  end

  assign rot_x     = s6_rot[0];
  assign rot_y     = s6_rot[1];
  assign rot_z     = s6_rot[2];
  assign saturated = s6_sat;

  // A held pipeline keeps every item in place.
  `QVR_ASSERT_NEXT(a_stall_holds, !rst && !adv, $stable(vld), "stall moved an item")
  // An accepted item occupies the first stage.
  `QVR_ASSERT_NEXT(a_accept_enters, !rst && in_valid && in_ready, vld[0], "accepted item lost")
  // A saturated result sits on a rail in at least one component.
  `QVR_ASSERT_NOW(a_sat_on_rail, out_valid && saturated,
    rot_x == OUT_MAX || rot_x == OUT_MIN || rot_y == OUT_MAX || rot_y == OUT_MIN ||
    rot_z == OUT_MAX || rot_z == OUT_MIN, "saturation flag without clipped value")

endmodule
